[hdl/bpe_pkg.sv]
// ----------------------------------------------------------------------------
// bpe_pkg
// shared constants and types of the bezier point evaluator
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 24;
  localparam int T_FRAC_BITS_DEF = 16;

  // fixed field widths of the item and the register
  localparam int INDEX_WIDTH = 4;
  localparam int COUNT_WIDTH = 5;
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 5'd4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

[hdl/bpe_point_mem.sv]
// ----------------------------------------------------------------------------
// bpe_point_mem
// point store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpe_point_mem #(
  parameter int DEPTH = bpe_pkg::MAX_POINTS_DEF,
  parameter int WIDTH = 2 * bpe_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/bpe_lerp_unit.sv]
// ----------------------------------------------------------------------------
// bpe_lerp_unit
// three-stage interpolation a + t*(b-a), rounded half up
// ----------------------------------------------------------------------------
module bpe_lerp_unit #(
  parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [T_FRAC_BITS:0]          t,
  input  logic signed [COORD_WIDTH-1:0] a,
  input  logic signed [COORD_WIDTH-1:0] b,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] res,
  output logic                          busy
);

  localparam int AccW = COORD_WIDTH + T_FRAC_BITS + 3;
  localparam logic signed [AccW-1:0] Half = AccW'(1) << (T_FRAC_BITS - 1);

  logic                          va, vb;
  logic signed [COORD_WIDTH:0]   diff;
  logic signed [COORD_WIDTH-1:0] a_a, a_b;
  logic signed [AccW-1:0]        prod;
  logic signed [AccW-1:0]        acc;

  // (1-t)*a + t*b written as a*2^T + t*(b-a)
  always_ff @(posedge clk) begin
    diff <= {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
    a_a  <= a;
    prod <= $signed({1'b0, t}) * diff;
    a_b  <= a_a;
    res  <= acc[T_FRAC_BITS +: COORD_WIDTH];
  end

  always_comb begin
    acc = $signed({{3{a_b[COORD_WIDTH-1]}}, a_b, {T_FRAC_BITS{1'b0}}}) + prod + Half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  assign busy = va | vb | out_valid;

endmodule

[hdl/bezier_point_evaluator.sv]
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// de casteljau evaluation of a bezier curve over stored control points
// ----------------------------------------------------------------------------
// a load item is written into the control store as it is taken; an evaluate item
// walks the levels of its n points down to a single point:
// one memory read per cycle feeds the shared lerp pair, and each level drains the
// 5-stage read/lerp/write-back loop before the next level reads it.
// one item in work at a time; the next can be taken in the cycle in which the result shows.
// reset (synchronous) returns to idle, point_count = 4, stores are not cleared.
module bezier_point_evaluator #(
  parameter int MAX_POINTS  = bpe_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               point_count_we,
  input  logic [bpe_pkg::COUNT_WIDTH-1:0]    point_count,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic [bpe_pkg::INDEX_WIDTH-1:0]    point_index,
  input  logic signed [COORD_WIDTH-1:0]      point_x,
  input  logic signed [COORD_WIDTH-1:0]      point_y,
  input  logic [T_FRAC_BITS:0]               t_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_WIDTH-1:0]      curve_x,
  output logic signed [COORD_WIDTH-1:0]      curve_y
);

  import bpe_pkg::*;

  localparam int IdxW  = $clog2(MAX_POINTS);
  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int PairW = 2 * COORD_WIDTH;
  localparam logic [T_FRAC_BITS:0] TOne = {1'b1, {T_FRAC_BITS{1'b0}}};

  state_t state, state_next;

  logic [COUNT_WIDTH-1:0] count_cfg;
  logic [CntW-1:0]        n_sat, n_m1;
  logic [IdxW-1:0]        m_start;
  logic [T_FRAC_BITS:0]   t_sat, t_q;

  logic            in_fire, load_we, eval_start;
  logic            issue, last_issue, out_load, pipe_busy;
  logic [IdxW-1:0] rd_idx, lvl_m;
  logic            from_ctrl;

  logic            p1_valid, p1_first, p1_ctrl, p1_single, p1_last;
  logic [IdxW-1:0] p1_waddr;
  logic [IdxW-1:0] wtag [3];
  logic            last_tag [3];

  logic [PairW-1:0]              ctrl_rdata, scr_rdata, rd;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y, prev_x, prev_y;
  logic signed [COORD_WIDTH-1:0] lx_res, ly_res, res_x, res_y;
  logic                          lerp_go, lx_valid, ly_valid, lx_busy, ly_busy;

  assign in_fire    = in_valid && !in_stall;
  assign load_we    = in_fire && (opcode == OP_LOAD) && (int'(point_index) < MAX_POINTS);
  assign eval_start = in_fire && (opcode == OP_EVAL);
  assign last_issue = (rd_idx == lvl_m);
  assign pipe_busy  = p1_valid | lx_busy | ly_busy;

  // point count and t clamped to their legal ranges
  always_comb begin
    if (count_cfg == '0) begin
      n_sat = CntW'(1);
    end else if (int'(count_cfg) > MAX_POINTS) begin
      n_sat = CntW'(MAX_POINTS);
    end else begin
      n_sat = CntW'(count_cfg);
    end
    n_m1    = n_sat - CntW'(1);
    m_start = n_m1[IdxW-1:0];
    t_sat   = (t_value > TOne) ? TOne : t_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= COUNT_RESET;
    end else if (point_count_we) begin
      count_cfg <= point_count;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (eval_start) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = (lvl_m <= IdxW'(1)) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_ISSUE: issue    = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load = !out_valid || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_start) begin
      lvl_m     <= m_start;
      rd_idx    <= '0;
      from_ctrl <= 1'b1;
      t_q       <= t_sat;
    end else if (issue) begin
      rd_idx <= rd_idx + IdxW'(1);
    end else if (state == ST_DRAIN && !pipe_busy) begin
      // next level reads back the scratch store
      lvl_m     <= lvl_m - IdxW'(1);
      rd_idx    <= '0;
      from_ctrl <= 1'b0;
    end
  end

  bpe_point_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (PairW)
  ) u_ctrl_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (IdxW'(point_index)),
    .wdata ({point_y, point_x}),
    .raddr (rd_idx),
    .rdata (ctrl_rdata)
  );

  bpe_point_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (PairW)
  ) u_scratch_mem (
    .clk   (clk),
    .we    (lx_valid),
    .waddr (wtag[2]),
    .wdata ({ly_res, lx_res}),
    .raddr (rd_idx),
    .rdata (scr_rdata)
  );

  // read stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    p1_first  <= (rd_idx == '0);
    p1_ctrl   <= from_ctrl;
    p1_single <= (lvl_m == '0);
    p1_last   <= (lvl_m == IdxW'(1));
    p1_waddr  <= rd_idx - IdxW'(1);
  end

  assign rd      = p1_ctrl ? ctrl_rdata : scr_rdata;
  assign rd_x    = rd[COORD_WIDTH-1:0];
  assign rd_y    = rd[PairW-1:COORD_WIDTH];
  assign lerp_go = p1_valid && !p1_first && !p1_single;

  // previous entry of the level is the left operand
  always_ff @(posedge clk) begin
    if (p1_valid) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    wtag[0]     <= p1_waddr;
    wtag[1]     <= wtag[0];
    wtag[2]     <= wtag[1];
    last_tag[0] <= p1_last;
    last_tag[1] <= last_tag[0];
    last_tag[2] <= last_tag[1];
  end

  bpe_lerp_unit #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lerp_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lerp_go),
    .t         (t_q),
    .a         (prev_x),
    .b         (rd_x),
    .out_valid (lx_valid),
    .res       (lx_res),
    .busy      (lx_busy)
  );

  bpe_lerp_unit #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lerp_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lerp_go),
    .t         (t_q),
    .a         (prev_y),
    .b         (rd_y),
    .out_valid (ly_valid),
    .res       (ly_res),
    .busy      (ly_busy)
  );

  // final point: the single lerp of the last level, or point 0 alone
  always_ff @(posedge clk) begin
    if (p1_valid && p1_single) begin
      res_x <= rd_x;
      res_y <= rd_y;
    end else if (lx_valid && last_tag[2]) begin
      res_x <= lx_res;
      res_y <= ly_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      curve_x <= res_x;
      curve_y <= res_y;
    end
  end

  a_axes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lx_valid == ly_valid)
    else $error("lerp units out of step");

  a_writeback_in_eval: assert property (@(posedge clk) disable iff (rst)
    lx_valid |-> (state == ST_ISSUE || state == ST_DRAIN))
    else $error("scratch write outside an evaluation");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (rd_idx <= lvl_m))
    else $error("read index past the level");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result shown without a finished evaluation");

endmodule

[tb/sv/bezier_point_evaluator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bezier_point_evaluator_tb
// loads control points and evaluates the curve at many t values under random
// idling and back pressure; each curve point is checked against a local
// de casteljau predictor that tracks the point store and the point count
// ----------------------------------------------------------------------------
module bezier_point_evaluator_tb;
  import bpe_pkg::*;

  localparam int MAX_PTS = MAX_POINTS_DEF;
  localparam int COORD_W = COORD_WIDTH_DEF;
  localparam int T_BITS  = T_FRAC_BITS_DEF;
  localparam longint T_ONE = longint'(1) <<< T_BITS;
  localparam int LIMIT = 1_000_000;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE_CYCLES = 10;
  localparam int NUM_PHASES = 16;
  localparam int PHASE_COUNTS [NUM_PHASES] = '{3, 2, 1, 5, 16, 4, 0, 7, 31, 6, 2, 12, 8,
                                               3, 17, 5};
  localparam int STEADY_PHASE = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_BITS:0] tval_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } curve_pt_t;

  logic clk;
  logic rst;
  logic point_count_we;
  logic [COUNT_WIDTH-1:0] point_count;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic [INDEX_WIDTH-1:0] point_index;
  coord_t point_x;
  coord_t point_y;
  tval_t t_value;
  logic out_valid;
  logic out_stall;
  coord_t curve_x;
  coord_t curve_y;

  // predictor state
  coord_t pts_x [MAX_PTS];
  coord_t pts_y [MAX_PTS];
  int active_count = int'(COUNT_RESET);
  curve_pt_t expected_points [$];

  int errors = 0;
  int cycles = 0;
  bit steady = 1'b0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;

  bezier_point_evaluator dut (
    .clk            (clk),
    .rst            (rst),
    .point_count_we (point_count_we),
    .point_count    (point_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .point_index    (point_index),
    .point_x        (point_x),
    .point_y        (point_y),
    .t_value        (t_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .curve_x        (curve_x),
    .curve_y        (curve_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("bezier_point_evaluator: mismatch");
      $finish;
    end
  end

  // one interpolation step, rounded half up
  function automatic coord_t blend_coord(input coord_t a, input coord_t b, input longint w);
    longint acc;
    longint shifted;
    acc = (T_ONE - w) * longint'(a) + w * longint'(b) + (T_ONE >>> 1);
    shifted = acc >>> T_BITS;
    return shifted[COORD_W-1:0];
  endfunction

  function automatic curve_pt_t curve_at(input tval_t t_raw);
    coord_t wx [MAX_PTS];
    coord_t wy [MAX_PTS];
    int n;
    longint w;
    curve_pt_t p;
    n = (active_count == 0) ? 1 : (active_count > MAX_PTS) ? MAX_PTS : active_count;
    w = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
    for (int i = 0; i < n; i++) begin
      wx[i] = pts_x[i];
      wy[i] = pts_y[i];
    end
    for (int lvl = 1; lvl < n; lvl++) begin
      for (int i = 0; i + lvl < n; i++) begin
        wx[i] = blend_coord(wx[i], wx[i+1], w);
        wy[i] = blend_coord(wy[i], wy[i+1], w);
      end
    end
    p.x = wx[0];
    p.y = wy[0];
    return p;
  endfunction

  function automatic tval_t rand_t();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 8) return tval_t'(T_ONE);
    // t above one saturates
    if (pick < 14) return tval_t'($urandom_range(int'(T_ONE) + 1, (1 << (T_BITS + 1)) - 1));
    return tval_t'($urandom_range(0, int'(T_ONE)));
  endfunction

  task automatic send_item(input op_t op, input logic [INDEX_WIDTH-1:0] idx,
                           input coord_t x, input coord_t y, input tval_t t);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 23) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    point_index <= idx;
    point_x <= x;
    point_y <= y;
    t_value <= t;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      pts_x[idx] = x;
      pts_y[idx] = y;
    end else begin
      expected_points.push_back(curve_at(t));
    end
  endtask

  task automatic send_eval(input tval_t t);
    send_item(OP_EVAL, INDEX_WIDTH'($urandom), coord_t'($urandom), coord_t'($urandom), t);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    point_count_we <= 1'b1;
    point_count <= COUNT_WIDTH'(value);
    @(posedge clk);
    point_count_we <= 1'b0;
    active_count = value;
  endtask

  always @(posedge clk) begin : check_result
    curve_pt_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("result with nothing expected: curve_x=%0d curve_y=%0d", curve_x, curve_y);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (curve_x !== want.x) begin
          $error("curve_x expected %0d actual %0d", want.x, curve_x);
          errors++;
        end
        if (curve_y !== want.y) begin
          $error("curve_y expected %0d actual %0d", want.y, curve_y);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_stall <= 1'b1;
      hold_given <= hold_given + 1;
      hold_left <= HOLD_LEN;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 23);
    end
  end

  // every slot gets written so no evaluation reads an empty slot
  task automatic test_load_extremes();
    coord_t cmax;
    coord_t cmin;
    cmax = {1'b0, {(COORD_W-1){1'b1}}};
    cmin = {1'b1, {(COORD_W-1){1'b0}}};
    for (int i = 0; i < MAX_PTS; i++) begin
      case (i % 4)
        0: send_item(OP_LOAD, INDEX_WIDTH'(i), cmax, cmin, '0);
        1: send_item(OP_LOAD, INDEX_WIDTH'(i), cmin, cmax, {(T_BITS+1){1'b1}});
        2: send_item(OP_LOAD, INDEX_WIDTH'(i), '0, '1, '0);
        default: send_item(OP_LOAD, INDEX_WIDTH'(i), coord_t'($urandom), coord_t'($urandom),
                           '0);
      endcase
    end
  endtask

  task automatic test_reset_count();
    send_eval('0);
    send_eval(tval_t'(T_ONE));
    send_eval(tval_t'(T_ONE >>> 1));
    send_eval({(T_BITS+1){1'b1}});
  endtask

  // one point, zero (taken as one) and counts at and above the store size
  task automatic test_count_edges();
    int edge_counts [4] = '{1, 0, MAX_PTS, 31};
    for (int i = 0; i < 4; i++) begin
      settle();
      write_count(edge_counts[i]);
      send_eval(tval_t'(1 + i * 20000));
    end
  endtask

  task automatic test_backpressure();
    settle();
    write_count(4);
    hold_asked++;
    repeat (12) send_eval(rand_t());
  endtask

  task automatic test_random();
    int n_items;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_count(PHASE_COUNTS[ph]);
      steady = (ph == STEADY_PHASE);
      n_items = (PHASE_COUNTS[ph] >= 12) ? 12 : 40;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 40)
          send_item(OP_LOAD, INDEX_WIDTH'($urandom), coord_t'($urandom), coord_t'($urandom),
                    tval_t'($urandom));
        else
          send_eval(rand_t());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    point_count_we <= 1'b0;
    point_count <= COUNT_RESET;
    in_valid <= 1'b0;
    opcode <= OP_LOAD;
    point_index <= '0;
    point_x <= '0;
    point_y <= '0;
    t_value <= '0;
    out_stall <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_extremes();
    test_reset_count();
    test_count_edges();
    test_backpressure();
    test_random();

    settle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("bezier_point_evaluator: match");
    end else begin
      $display("bezier_point_evaluator: mismatch");
    end
    $finish;
  end

endmodule
